// ===== design/psi_pkg.sv =====
// ----------------------------------------------------------------------------
// Proximity safety interlock package
// Shared types, codes and reset values for the interlock block.
// ----------------------------------------------------------------------------
package psi_pkg;

  typedef enum logic [1:0] {
    LV_CLEAR   = 2'd0,
    LV_CAUTION = 2'd1,
    LV_STOP    = 2'd2,
    LV_ESTOP   = 2'd3
  } level_e;

  typedef enum logic [2:0] {
    RS_NONE      = 3'd0,
    RS_DIST_STOP = 3'd1,
    RS_CAUTION   = 3'd2,
    RS_TIMEOUT   = 3'd3,
    RS_RANGE     = 3'd4,
    RS_STALE     = 3'd5,
    RS_INIT      = 3'd6,
    RS_MANUAL    = 3'd7
  } reason_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ECHO = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_RANGE   = 3'd3,
    ST_STALE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_STOP_ENTER    = 3'd0,
    REG_STOP_CLEAR    = 3'd1,
    REG_CAUTION_ENTER = 3'd2,
    REG_CAUTION_CLEAR = 3'd3,
    REG_STALE_TIMEOUT = 3'd4,
    REG_CLEAR_NEED    = 3'd5,
    REG_ALLOW_REVERSE = 3'd6,
    REG_ENFORCE       = 3'd7
  } reg_idx_e;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned InW    = 120;
  localparam int unsigned OutW   = 48;
  localparam logic [7:0]  CountMax = 8'hFF;

  localparam logic [15:0] StopEnterRst    = 16'd400;
  localparam logic [15:0] StopClearRst    = 16'd500;
  localparam logic [15:0] CautionEnterRst = 16'd600;
  localparam logic [15:0] CautionClearRst = 16'd650;
  localparam logic [15:0] StaleTimeoutRst = 16'd500;
  localparam logic [7:0]  ClearNeedRst    = 8'd3;

  // Input word, last member in the lowest bits
  typedef struct packed {
    logic        moving_reverse;
    logic        reverse_cmd;
    logic        latch_reset_req;
    logic        motor_idle;
    logic        estop_pressed;
    logic [31:0] now_ms;
    logic [31:0] sample_sequence;
    logic [31:0] sample_at_ms;
    logic [2:0]  sensor_status;
    logic [15:0] distance_mm;
  } in_word_t;

  typedef struct packed {
    logic [31:0] eval_at_ms;
    logic        drive_disable;
    logic        halt_req;
    logic        reverse_inhibit;
    logic        latched;
    logic        rev_exposed;
    logic [2:0]  reason_code;
    logic [1:0]  level;
  } out_word_t;

endpackage

// ===== design/proximity_safety_interlock.sv =====
// ----------------------------------------------------------------------------
// Proximity safety interlock
// Distance thresholds with hysteresis, stale-sample check, latched estop and
// reverse blocking, one evaluation per stream word.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes through the input register, then the
//   result register, which holds its word while the output is stalled.
// Throughput: one word per cycle while the output is ready; the state
//   update is a single pass of compares and muxes from input to result register.
// Reset: rst_ni clears all control state; level resets to stop with reason
//   init, the latch and clear count to zero, registers to their defaults.
module proximity_safety_interlock
  import psi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: distance_mm[15:0], sensor_status[2:0], sample_at_ms[31:0],
  // sample_sequence[31:0], now_ms[31:0], estop_pressed, motor_idle,
  // latch_reset_req, reverse_cmd, moving_reverse
  input  logic [InW-1:0]      s_axis_tdata,
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: level[1:0], reason_code[2:0], rev_exposed,
  // latched, reverse_inhibit, halt_req, drive_disable,
  // eval_at_ms[31:0], zero pad[5:0]
  output logic [OutW-1:0]     m_axis_tdata,
  // APB config
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // config registers
  logic [15:0] stop_enter_q, stop_clear_q, caution_enter_q, caution_clear_q;
  logic [15:0] stale_timeout_q;
  logic [7:0]  clear_need_q;
  logic        allow_reverse_q, enforce_q;

  // pipeline
  logic      in_valid_q, out_valid_q;
  in_word_t  in_q;
  out_word_t out_q, out_d;
  logic      advance, fire;

  // interlock state
  level_e      level_q, level_d;
  reason_e     reason_q, reason_d;
  logic        latch_q, latch_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] last_seq_q, last_seq_d;
  logic        seen_q, seen_d;

  logic        wr_en;
  reg_idx_e    wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_enter_q    <= StopEnterRst;
      stop_clear_q    <= StopClearRst;
      caution_enter_q <= CautionEnterRst;
      caution_clear_q <= CautionClearRst;
      stale_timeout_q <= StaleTimeoutRst;
      clear_need_q    <= ClearNeedRst;
      allow_reverse_q <= 1'b0;
      enforce_q       <= 1'b1;
    end else if (wr_en) begin
      case (wr_idx)
        REG_STOP_ENTER:    stop_enter_q    <= pwdata[15:0];
        REG_STOP_CLEAR:    stop_clear_q    <= pwdata[15:0];
        REG_CAUTION_ENTER: caution_enter_q <= pwdata[15:0];
        REG_CAUTION_CLEAR: caution_clear_q <= pwdata[15:0];
        REG_STALE_TIMEOUT: stale_timeout_q <= pwdata[15:0];
        REG_CLEAR_NEED:    clear_need_q    <= pwdata[7:0];
        REG_ALLOW_REVERSE: allow_reverse_q <= pwdata[0];
        REG_ENFORCE:       enforce_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_STOP_ENTER:    prdata = {16'd0, stop_enter_q};
      REG_STOP_CLEAR:    prdata = {16'd0, stop_clear_q};
      REG_CAUTION_ENTER: prdata = {16'd0, caution_enter_q};
      REG_CAUTION_CLEAR: prdata = {16'd0, caution_clear_q};
      REG_STALE_TIMEOUT: prdata = {16'd0, stale_timeout_q};
      REG_CLEAR_NEED:    prdata = {24'd0, clear_need_q};
      REG_ALLOW_REVERSE: prdata = {31'd0, allow_reverse_q};
      REG_ENFORCE:       prdata = {31'd0, enforce_q};
      default:           prdata = '0;
    endcase
  end

  // handshake: result register frees when empty or taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutW - $bits(out_word_t)){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= LV_STOP;
      reason_q    <= RS_INIT;
      latch_q     <= 1'b0;
      count_q     <= '0;
      last_seq_q  <= '0;
      seen_q      <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance)       out_valid_q <= in_valid_q;
      if (fire) begin
        level_q    <= level_d;
        reason_q   <= reason_d;
        latch_q    <= latch_d;
        count_q    <= count_d;
        last_seq_q <= last_seq_d;
        seen_q     <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q  <= in_word_t'(s_axis_tdata);
    if (fire)                           out_q <= out_d;
  end

  // evaluation
  logic [31:0] age;
  logic        stale, fresh, rev_unprot, release_ok, done;
  logic [15:0] dist_eval;
  status_e     status;

  always_comb begin
    status     = status_e'(in_q.sensor_status);
    age        = in_q.now_ms - in_q.sample_at_ms;
    rev_unprot = !allow_reverse_q && (in_q.reverse_cmd || in_q.moving_reverse);
    stale      = 1'b0;
    fresh      = 1'b0;
    level_d    = level_q;
    reason_d   = reason_q;
    latch_d    = latch_q;
    count_d    = count_q;
    last_seq_d = last_seq_q;
    seen_d     = seen_q;
    done       = 1'b0;
    release_ok = 1'b0;
    dist_eval  = (status == ST_NO_ECHO) ? caution_clear_q : in_q.distance_mm;

    if (enforce_q) begin
      // a zero sample time means never sampled: age is now itself
      if (in_q.sample_at_ms == 32'd0) stale = in_q.now_ms > {16'd0, stale_timeout_q};
      else                            stale = age > {16'd0, stale_timeout_q};
      fresh = !seen_q || (in_q.sample_sequence != last_seq_q);
      if (fresh) begin
        last_seq_d = in_q.sample_sequence;
        seen_d     = 1'b1;
      end
    end

    if (in_q.estop_pressed) begin
      level_d  = LV_ESTOP;
      reason_d = RS_MANUAL;
      latch_d  = 1'b1;
      count_d  = '0;
    end

    if (latch_d) begin
      release_ok = in_q.latch_reset_req && !in_q.estop_pressed && in_q.motor_idle;
      if (enforce_q) begin
        release_ok = release_ok && (status inside {ST_OK, ST_NO_ECHO}) && !stale &&
                     ((status == ST_NO_ECHO) || (in_q.distance_mm >= caution_enter_q));
      end
      if (!release_ok) begin
        done = 1'b1;
      end else begin
        latch_d  = 1'b0;
        level_d  = LV_CLEAR;
        reason_d = RS_NONE;
        count_d  = '0;
      end
    end

    if (!done) begin
      if (!enforce_q) begin
        level_d  = LV_CLEAR;
        reason_d = RS_NONE;
        count_d  = '0;
      end else if (stale && (status inside {ST_OK, ST_NO_ECHO})) begin
        level_d  = LV_STOP;
        reason_d = RS_STALE;
        count_d  = '0;
      end else if (!(status inside {ST_OK, ST_NO_ECHO})) begin
        level_d = LV_STOP;
        count_d = '0;
        case (status)
          ST_TIMEOUT: reason_d = RS_TIMEOUT;
          ST_RANGE:   reason_d = RS_RANGE;
          ST_STALE:   reason_d = RS_STALE;
          default:    reason_d = RS_INIT;
        endcase
      end else if (dist_eval < stop_enter_q) begin
        level_d  = LV_STOP;
        reason_d = RS_DIST_STOP;
        count_d  = '0;
      end else begin
        // hold stop until enough new clear samples have been counted
        if (level_d == LV_STOP) begin
          if (dist_eval >= stop_clear_q) begin
            if (fresh && (count_d != CountMax)) count_d = count_d + 8'd1;
          end else begin
            count_d = '0;
          end
          if (count_d < clear_need_q) begin
            reason_d = RS_DIST_STOP;
            done     = 1'b1;
          end
        end
        if (!done) begin
          count_d = '0;
          if (dist_eval < caution_enter_q) begin
            level_d  = LV_CAUTION;
            reason_d = RS_CAUTION;
          end else if ((level_d == LV_CAUTION) && (dist_eval < caution_clear_q)) begin
            reason_d = RS_CAUTION;
          end else begin
            level_d  = LV_CLEAR;
            reason_d = RS_NONE;
          end
        end
      end
    end

    out_d.level           = (rev_unprot && !latch_d) ? LV_STOP : level_d;
    out_d.reason_code     = reason_d;
    out_d.rev_exposed     = rev_unprot;
    out_d.latched         = latch_d;
    out_d.reverse_inhibit = rev_unprot;
    out_d.halt_req        = (level_d == LV_STOP) || latch_d || rev_unprot;
    out_d.drive_disable   = latch_d;
    out_d.eval_at_ms      = in_q.now_ms;
  end

  // assertions
  a_latch_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> (level_q == LV_ESTOP))
    else $error("latch set without estop level");

  a_estop_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == LV_ESTOP) |-> latch_q)
    else $error("estop level without latch");

  a_count_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 8'd0) |-> (level_q == LV_STOP))
    else $error("clear count running outside stop level");

  a_seq_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (last_seq_q == 32'd0))
    else $error("sequence recorded without seen flag");

  a_stop_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.halt_req) |-> (out_q.level != LV_STOP))
    else $error("stop level reported without halt request");

endmodule
